[rtl/scbx_pkg.sv]
`default_nettype none

package scbx_pkg;

    localparam int RX_DEPTH = 256;
    localparam int TX_DEPTH = 256;
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int LEVEL_W = (RX_AW > 8) ? RX_AW : 8;
    localparam int THR_W = (RX_AW > 9) ? RX_AW : 9;

    localparam logic [2:0] OP_RX_BYTE    = 3'd0;
    localparam logic [2:0] OP_RX_ERROR   = 3'd1;
    localparam logic [2:0] OP_HOST_READ  = 3'd2;
    localparam logic [2:0] OP_HOST_WRITE = 3'd3;
    localparam logic [2:0] OP_TX_DONE    = 3'd4;
    localparam logic [2:0] OP_LINE_EVENT = 3'd5;

    localparam logic [1:0] CFG_RX_MASK        = 2'd0;
    localparam logic [1:0] CFG_XOFF_ENABLE    = 2'd1;
    localparam logic [1:0] CFG_XOFF_THRESHOLD = 2'd2;

    localparam logic [7:0] RX_MASK_RESET        = 8'h7f;
    localparam logic [8:0] XOFF_THRESHOLD_RESET = 9'd176;

    localparam logic [7:0] OVERRUN_BIT = 8'h08;
    localparam logic [7:0] RX_ERR_BITS = 8'h70;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] XOFF_CHAR   = 8'h13;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] ptr);
        logic [RX_AW-1:0] res;
        if (ptr == RX_AW'(RX_DEPTH - 1))
            res = '0;
        else
            res = ptr + RX_AW'(1);
        return res;
    endfunction

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] ptr);
        logic [TX_AW-1:0] res;
        if (ptr == TX_AW'(TX_DEPTH - 1))
            res = '0;
        else
            res = ptr + TX_AW'(1);
        return res;
    endfunction

    function automatic logic [RX_AW-1:0] rx_fill(input logic [RX_AW-1:0] wp,
                                                  input logic [RX_AW-1:0] rp);
        logic [RX_AW:0] sum;
        if (wp >= rp)
            sum = {1'b0, wp} - {1'b0, rp};
        else
            sum = {1'b0, wp} + (RX_AW+1)'(RX_DEPTH) - {1'b0, rp};
        return sum[RX_AW-1:0];
    endfunction

    function automatic logic [TX_AW-1:0] tx_fill(input logic [TX_AW-1:0] wp,
                                                  input logic [TX_AW-1:0] rp);
        logic [TX_AW:0] sum;
        if (wp >= rp)
            sum = {1'b0, wp} - {1'b0, rp};
        else
            sum = {1'b0, wp} + (TX_AW+1)'(TX_DEPTH) - {1'b0, rp};
        return sum[TX_AW-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/scbx_ram.sv]
`default_nettype none

module scbx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/scbx_ctrl.sv]
`default_nettype none

module scbx_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    output scbx_pkg::cmd_t    cmd
);

    scbx_pkg::state_t state_reg;
    scbx_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scbx_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = scbx_pkg::ST_EXEC;
                end
            end
            scbx_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = scbx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scbx_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            scbx_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            scbx_pkg::ST_EXEC:
            begin
                cmd.exec = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scbx_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/scbx_datapath.sv]
`default_nettype none

module scbx_datapath (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire scbx_pkg::cmd_t cmd,
    input  wire logic [2:0]   opcode,
    input  wire logic [7:0]   in_byte,
    input  wire logic [7:0]   line_status,
    input  wire logic         cfg_valid,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [8:0]   cfg_data,
    output logic              ok,
    output logic [7:0]        read_byte,
    output logic [7:0]        read_flags,
    output logic              send_valid,
    output logic [7:0]        send_byte,
    output logic [7:0]        error_flags,
    output logic [7:0]        rx_level
);

    logic [2:0]       op_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       line_reg;

    logic [7:0]       rx_mask_reg;
    logic             xoff_enable_reg;
    logic [8:0]       xoff_threshold_reg;

    logic [scbx_pkg::RX_AW-1:0] rx_wp_reg, rx_wp_next;
    logic [scbx_pkg::RX_AW-1:0] rx_rp_reg, rx_rp_next;
    logic [scbx_pkg::TX_AW-1:0] tx_wp_reg, tx_wp_next;
    logic [scbx_pkg::TX_AW-1:0] tx_rp_reg, tx_rp_next;
    logic             tx_busy_reg, tx_busy_next;
    logic [7:0]       sticky_reg, sticky_next;

    logic             ok_reg, ok_next;
    logic [7:0]       read_byte_reg, read_byte_next;
    logic [7:0]       read_flags_reg, read_flags_next;
    logic             send_valid_reg, send_valid_next;
    logic [7:0]       send_byte_reg, send_byte_next;
    logic [7:0]       rx_level_reg, rx_level_next;

    logic             rx_data_we;
    logic             rx_stat_we;
    logic [7:0]       rx_data_wdata;
    logic [7:0]       rx_stat_wdata;
    logic [7:0]       rx_data_rdata;
    logic [7:0]       rx_stat_rdata;
    logic             tx_we;
    logic [7:0]       tx_rdata;

    logic [scbx_pkg::RX_AW-1:0] rx_cnt;
    logic [scbx_pkg::TX_AW-1:0] tx_cnt;
    logic [7:0]       status;
    logic             rx_full;
    logic             xoff_hit;
    logic [scbx_pkg::LEVEL_W-1:0] level_ext;

    scbx_ram #(.WIDTH(8), .DEPTH(scbx_pkg::RX_DEPTH)) u_rx_data_ram (
        .clk   (clk),
        .we    (rx_data_we),
        .waddr (rx_wp_reg),
        .wdata (rx_data_wdata),
        .re    (cmd.capture),
        .raddr (rx_rp_reg),
        .rdata (rx_data_rdata)
    );

    scbx_ram #(.WIDTH(8), .DEPTH(scbx_pkg::RX_DEPTH)) u_rx_stat_ram (
        .clk   (clk),
        .we    (rx_stat_we),
        .waddr (rx_wp_reg),
        .wdata (rx_stat_wdata),
        .re    (cmd.capture),
        .raddr (rx_rp_reg),
        .rdata (rx_stat_rdata)
    );

    scbx_ram #(.WIDTH(8), .DEPTH(scbx_pkg::TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wp_reg),
        .wdata (byte_reg),
        .re    (cmd.capture),
        .raddr (tx_rp_reg),
        .rdata (tx_rdata)
    );

    assign rx_cnt   = scbx_pkg::rx_fill(rx_wp_reg, rx_rp_reg);
    assign tx_cnt   = scbx_pkg::tx_fill(tx_wp_reg, tx_rp_reg);
    assign rx_full  = (rx_cnt == scbx_pkg::RX_AW'(scbx_pkg::RX_DEPTH - 1));
    assign xoff_hit = xoff_enable_reg && !tx_busy_reg
                      && (scbx_pkg::THR_W'(rx_cnt) >= scbx_pkg::THR_W'(xoff_threshold_reg));

    always_comb
    begin
        rx_wp_next      = rx_wp_reg;
        rx_rp_next      = rx_rp_reg;
        tx_wp_next      = tx_wp_reg;
        tx_rp_next      = tx_rp_reg;
        tx_busy_next    = tx_busy_reg;
        sticky_next     = sticky_reg;
        ok_next         = 1'b0;
        read_byte_next  = 8'h00;
        read_flags_next = 8'h00;
        send_valid_next = 1'b0;
        send_byte_next  = 8'h00;
        rx_data_we      = 1'b0;
        rx_stat_we      = 1'b0;
        tx_we           = 1'b0;
        status          = 8'h00;
        rx_data_wdata   = byte_reg;
        case (op_reg)
            scbx_pkg::OP_RX_BYTE, scbx_pkg::OP_RX_ERROR:
            begin
                if (op_reg == scbx_pkg::OP_RX_BYTE)
                begin
                    rx_data_wdata = byte_reg & rx_mask_reg;
                end
                else
                begin
                    status = line_reg & scbx_pkg::RX_ERR_BITS;
                end
                if (rx_full)
                begin
                    // The data half of the write slot is kept; only its status is replaced.
                    status     = status | scbx_pkg::OVERRUN_BIT;
                    rx_stat_we = 1'b1;
                end
                else
                begin
                    if (xoff_hit)
                    begin
                        tx_busy_next    = 1'b1;
                        send_valid_next = 1'b1;
                        send_byte_next  = scbx_pkg::XOFF_CHAR;
                    end
                    rx_data_we = 1'b1;
                    rx_stat_we = 1'b1;
                    rx_wp_next = scbx_pkg::rx_inc(rx_wp_reg);
                    ok_next    = 1'b1;
                end
                sticky_next = sticky_reg | status;
            end
            scbx_pkg::OP_HOST_READ:
            begin
                if (rx_cnt != '0)
                begin
                    read_byte_next  = rx_data_rdata;
                    read_flags_next = rx_stat_rdata;
                    rx_rp_next      = scbx_pkg::rx_inc(rx_rp_reg);
                    ok_next         = 1'b1;
                end
            end
            scbx_pkg::OP_HOST_WRITE:
            begin
                if (tx_cnt != scbx_pkg::TX_AW'(scbx_pkg::TX_DEPTH - 1))
                begin
                    tx_we      = 1'b1;
                    tx_wp_next = scbx_pkg::tx_inc(tx_wp_reg);
                    ok_next    = 1'b1;
                    if ((tx_cnt == '0) && !tx_busy_reg)
                    begin
                        // The new byte is popped straight away to start the transmitter.
                        send_valid_next = 1'b1;
                        send_byte_next  = byte_reg;
                        tx_rp_next      = scbx_pkg::tx_inc(tx_rp_reg);
                        tx_busy_next    = 1'b1;
                    end
                end
            end
            scbx_pkg::OP_TX_DONE:
            begin
                if (tx_cnt != '0)
                begin
                    ok_next         = 1'b1;
                    send_valid_next = 1'b1;
                    send_byte_next  = tx_rdata;
                    tx_rp_next      = scbx_pkg::tx_inc(tx_rp_reg);
                end
                else
                begin
                    tx_busy_next = 1'b0;
                end
            end
            scbx_pkg::OP_LINE_EVENT:
            begin
                sticky_next = sticky_reg | (line_reg & scbx_pkg::BREAK_BIT);
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        rx_data_we    = rx_data_we & cmd.exec;
        rx_stat_we    = rx_stat_we & cmd.exec;
        tx_we         = tx_we & cmd.exec;
        rx_stat_wdata = status;
        level_ext     = scbx_pkg::LEVEL_W'(scbx_pkg::rx_fill(rx_wp_next, rx_rp_next));
        rx_level_next = level_ext[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            byte_reg <= in_byte;
            line_reg <= line_status;
        end
        if (cmd.exec)
        begin
            ok_reg         <= ok_next;
            read_byte_reg  <= read_byte_next;
            read_flags_reg <= read_flags_next;
            send_valid_reg <= send_valid_next;
            send_byte_reg  <= send_byte_next;
            rx_level_reg   <= rx_level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wp_reg          <= '0;
            rx_rp_reg          <= '0;
            tx_wp_reg          <= '0;
            tx_rp_reg          <= '0;
            tx_busy_reg        <= 1'b0;
            sticky_reg         <= 8'h00;
            rx_mask_reg        <= scbx_pkg::RX_MASK_RESET;
            xoff_enable_reg    <= 1'b0;
            xoff_threshold_reg <= scbx_pkg::XOFF_THRESHOLD_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                rx_wp_reg   <= rx_wp_next;
                rx_rp_reg   <= rx_rp_next;
                tx_wp_reg   <= tx_wp_next;
                tx_rp_reg   <= tx_rp_next;
                tx_busy_reg <= tx_busy_next;
                sticky_reg  <= sticky_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    scbx_pkg::CFG_RX_MASK:        rx_mask_reg        <= cfg_data[7:0];
                    scbx_pkg::CFG_XOFF_ENABLE:    xoff_enable_reg    <= cfg_data[0];
                    scbx_pkg::CFG_XOFF_THRESHOLD: xoff_threshold_reg <= cfg_data;
                    default:                      rx_mask_reg        <= rx_mask_reg;
                endcase
            end
        end
    end

    assign ok          = ok_reg;
    assign read_byte   = read_byte_reg;
    assign read_flags  = read_flags_reg;
    assign send_valid  = send_valid_reg;
    assign send_byte   = send_byte_reg;
    assign error_flags = sticky_reg;
    assign rx_level    = rx_level_reg;

endmodule

`default_nettype wire

[rtl/serial_channel_buffers_xoff_unit.sv]
// A transaction is captured with the registered read port of the ring memories, then
// executed once the output is free, updating the rings and pointers and registering
// its result. A new transaction is taken only after the previous one has executed.
// Reset clears pointers, transmitter state, sticky errors and configuration to their
// defaults; ring contents are not cleared and need no clearing pass.
`default_nettype none

module serial_channel_buffers_xoff_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] opcode,
    input  wire logic [7:0] in_byte,
    input  wire logic [7:0] line_status,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            ok,
    output logic [7:0]      read_byte,
    output logic [7:0]      read_flags,
    output logic            send_valid,
    output logic [7:0]      send_byte,
    output logic [7:0]      error_flags,
    output logic [7:0]      rx_level,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data
);

    scbx_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    scbx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    scbx_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .in_byte     (in_byte),
        .line_status (line_status),
        .cfg_valid   (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ok          (ok),
        .read_byte   (read_byte),
        .read_flags  (read_flags),
        .send_valid  (send_valid),
        .send_byte   (send_byte),
        .error_flags (error_flags),
        .rx_level    (rx_level)
    );

endmodule

`default_nettype wire

[tb/tb_serial_channel_buffers_xoff_unit.sv]
module tb_serial_channel_buffers_xoff_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scbx_pkg::*;

    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic       ok;
        logic [7:0] read_byte;
        logic [7:0] read_flags;
        logic       send_valid;
        logic [7:0] send_byte;
        logic [7:0] error_flags;
        logic [7:0] rx_level;
    } chan_result_t;

    typedef struct {
        logic [2:0]   op;
        logic [7:0]   data;
        logic [7:0]   line;
        bit           typed;
        chan_result_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] opcode;
    logic [7:0] in_byte;
    logic [7:0] line_status;
    logic       out_valid;
    logic       out_stall;
    logic       ok;
    logic [7:0] read_byte;
    logic [7:0] read_flags;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [7:0] error_flags;
    logic [7:0] rx_level;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    logic [15:0] rx_ring [RX_DEPTH];
    logic [7:0]  tx_ring [TX_DEPTH];
    logic [7:0]  rx_wr;
    logic [7:0]  rx_rd;
    logic [7:0]  tx_wr;
    logic [7:0]  tx_rd;
    logic        tx_active;
    logic [7:0]  sticky_err;
    logic [7:0]  cfg_mask;
    logic        cfg_xoff_on;
    logic [8:0]  cfg_xoff_level;

    chan_result_t pending_q[$];
    stim_row_t    dir_rows[$];
    chan_result_t got;
    chan_result_t want;

    bit calm;
    bit hold_req;
    int fail_count;
    int item_count;
    int checked_count;
    int overrun_count;
    int xoff_count;
    int tx_drop_count;
    int holds_done;

    serial_channel_buffers_xoff_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .in_byte     (in_byte),
        .line_status (line_status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .read_byte   (read_byte),
        .read_flags  (read_flags),
        .send_valid  (send_valid),
        .send_byte   (send_byte),
        .error_flags (error_flags),
        .rx_level    (rx_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", checked_count, what);
        fail_count++;
    endtask

    function automatic chan_result_t res(input int o, input logic [7:0] rb, input logic [7:0] rf,
                                         input int sv, input logic [7:0] sb,
                                         input logic [7:0] ef, input logic [7:0] lv);
        return {1'(o), rb, rf, 1'(sv), sb, ef, lv};
    endfunction

    task automatic row(input logic [2:0] op, input logic [7:0] b, input logic [7:0] ln,
                       input bit typed, input chan_result_t w);
        stim_row_t r;
        r.op = op;
        r.data = b;
        r.line = ln;
        r.typed = typed;
        r.want = w;
        dir_rows.push_back(r);
    endtask

    task automatic predict_channel(input logic [2:0] op, input logic [7:0] b, input logic [7:0] ln,
                                   output chan_result_t r);
        logic [7:0] data;
        logic [7:0] status;
        logic [7:0] rx_fill;
        logic [7:0] tx_fill;
        r = '0;
        rx_fill = rx_wr - rx_rd;
        tx_fill = tx_wr - tx_rd;
        case (op)
            OP_RX_BYTE, OP_RX_ERROR:
            begin
                data = (op == OP_RX_BYTE) ? (b & cfg_mask) : b;
                status = (op == OP_RX_BYTE) ? 8'h00 : (ln & RX_ERR_BITS);
                if (rx_fill == 8'(RX_DEPTH - 1))
                begin
                    status |= OVERRUN_BIT;
                    rx_ring[rx_wr] = {status, rx_ring[rx_wr][7:0]};
                    overrun_count++;
                end
                else
                begin
                    if (cfg_xoff_on && {1'b0, rx_fill} >= cfg_xoff_level && !tx_active)
                    begin
                        tx_active = 1'b1;
                        r.send_valid = 1'b1;
                        r.send_byte = XOFF_CHAR;
                        xoff_count++;
                    end
                    rx_ring[rx_wr] = {status, data};
                    rx_wr++;
                    r.ok = 1'b1;
                end
                sticky_err |= status;
            end
            OP_HOST_READ:
            begin
                if (rx_fill != 8'd0)
                begin
                    r.read_byte = rx_ring[rx_rd][7:0];
                    r.read_flags = rx_ring[rx_rd][15:8];
                    rx_rd++;
                    r.ok = 1'b1;
                end
            end
            OP_HOST_WRITE:
            begin
                if (tx_fill != 8'(TX_DEPTH - 1))
                begin
                    tx_ring[tx_wr] = b;
                    tx_wr++;
                    r.ok = 1'b1;
                    if (tx_fill == 8'd0 && !tx_active)
                    begin
                        r.send_valid = 1'b1;
                        r.send_byte = tx_ring[tx_rd];
                        tx_rd++;
                        tx_active = 1'b1;
                    end
                end
                else
                begin
                    tx_drop_count++;
                end
            end
            OP_TX_DONE:
            begin
                if (tx_fill != 8'd0)
                begin
                    r.ok = 1'b1;
                    r.send_valid = 1'b1;
                    r.send_byte = tx_ring[tx_rd];
                    tx_rd++;
                end
                else
                begin
                    tx_active = 1'b0;
                end
            end
            OP_LINE_EVENT:
            begin
                sticky_err |= ln & BREAK_BIT;
            end
            default:
            begin
            end
        endcase
        r.error_flags = sticky_err;
        r.rx_level = rx_wr - rx_rd;
    endtask

    task automatic present(input logic [2:0] op, input logic [7:0] b, input logic [7:0] ln,
                           input bit typed, input chan_result_t w);
        chan_result_t pred;
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        in_byte <= b;
        line_status <= ln;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_channel(op, b, ln, pred);
        pending_q.push_back(typed ? w : pred);
        item_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_RX_MASK:        cfg_mask = d[7:0];
            CFG_XOFF_ENABLE:    cfg_xoff_on = d[0];
            CFG_XOFF_THRESHOLD: cfg_xoff_level = d;
            default:            ;
        endcase
    endtask

    task automatic configure(input logic [7:0] mask, input logic en, input logic [8:0] level);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        write_reg(CFG_RX_MASK, {1'b0, mask});
        write_reg(CFG_XOFF_ENABLE, {8'h00, en});
        write_reg(CFG_XOFF_THRESHOLD, level);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int w_rx, input int w_err, input int w_rd,
                             input int w_wr, input int w_done, input int w_line, input int w_bad);
        int pick;
        logic [2:0] op;
        logic [7:0] ln;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, w_rx + w_err + w_rd + w_wr + w_done + w_line + w_bad - 1);
            if (pick < w_rx)
                op = OP_RX_BYTE;
            else if (pick < w_rx + w_err)
                op = OP_RX_ERROR;
            else if (pick < w_rx + w_err + w_rd)
                op = OP_HOST_READ;
            else if (pick < w_rx + w_err + w_rd + w_wr)
                op = OP_HOST_WRITE;
            else if (pick < w_rx + w_err + w_rd + w_wr + w_done)
                op = OP_TX_DONE;
            else if (pick < w_rx + w_err + w_rd + w_wr + w_done + w_line)
                op = OP_LINE_EVENT;
            else
                op = ($urandom_range(0, 1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
            ln = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            present(op, 8'($urandom_range(0, 255)), ln, 1'b0, '0);
        end
    endtask

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
                holds_done++;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch("result arrived with no transaction pending");
            end
            else
            begin
                want = pending_q.pop_front();
                got = {ok, read_byte, read_flags, send_valid, send_byte, error_flags, rx_level};
                if (got.ok !== want.ok)
                    report_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
                if (got.read_byte !== want.read_byte)
                    report_mismatch($sformatf("read_byte %h, expected %h",
                                              got.read_byte, want.read_byte));
                if (got.read_flags !== want.read_flags)
                    report_mismatch($sformatf("read_flags %h, expected %h",
                                              got.read_flags, want.read_flags));
                if (got.send_valid !== want.send_valid)
                    report_mismatch($sformatf("send_valid %b, expected %b",
                                              got.send_valid, want.send_valid));
                if (got.send_byte !== want.send_byte)
                    report_mismatch($sformatf("send_byte %h, expected %h",
                                              got.send_byte, want.send_byte));
                if (got.error_flags !== want.error_flags)
                    report_mismatch($sformatf("error_flags %h, expected %h",
                                              got.error_flags, want.error_flags));
                if (got.rx_level !== want.rx_level)
                    report_mismatch($sformatf("rx_level %0d, expected %0d",
                                              got.rx_level, want.rx_level));
                checked_count++;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_RX_BYTE;
        in_byte <= 8'h00;
        line_status <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_RX_MASK;
        cfg_data <= 9'd0;
        for (int i = 0; i < RX_DEPTH; i++)
            rx_ring[i] = 16'h0000;
        for (int i = 0; i < TX_DEPTH; i++)
            tx_ring[i] = 8'h00;
        rx_wr = 8'd0;
        rx_rd = 8'd0;
        tx_wr = 8'd0;
        tx_rd = 8'd0;
        tx_active = 1'b0;
        sticky_err = 8'h00;
        cfg_mask = RX_MASK_RESET;
        cfg_xoff_on = 1'b0;
        cfg_xoff_level = XOFF_THRESHOLD_RESET;

        row(OP_HOST_READ,    8'h00, 8'h00, 1'b1, res(0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'd0));
        row(OP_TX_DONE,      8'h00, 8'h00, 1'b1, res(0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'd0));
        row(OP_RX_BYTE,      8'hff, 8'hff, 1'b1, res(1, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'd1));
        row(OP_RX_ERROR,     8'hff, 8'hff, 1'b1, res(1, 8'h00, 8'h00, 0, 8'h00, 8'h70, 8'd2));
        row(OP_HOST_READ,    8'h00, 8'h00, 1'b1, res(1, 8'h7f, 8'h00, 0, 8'h00, 8'h70, 8'd1));
        row(OP_HOST_READ,    8'h00, 8'h00, 1'b1, res(1, 8'hff, 8'h70, 0, 8'h00, 8'h70, 8'd0));
        row(OP_LINE_EVENT,   8'h00, 8'h7f, 1'b1, res(0, 8'h00, 8'h00, 0, 8'h00, 8'h70, 8'd0));
        row(OP_LINE_EVENT,   8'h00, 8'h80, 1'b1, res(0, 8'h00, 8'h00, 0, 8'h00, 8'hf0, 8'd0));
        row(OP_RSVD_6,       8'haa, 8'hff, 1'b1, res(0, 8'h00, 8'h00, 0, 8'h00, 8'hf0, 8'd0));
        row(OP_RSVD_7,       8'h55, 8'hff, 1'b1, res(0, 8'h00, 8'h00, 0, 8'h00, 8'hf0, 8'd0));
        row(OP_HOST_WRITE,   8'h00, 8'h00, 1'b1, res(1, 8'h00, 8'h00, 1, 8'h00, 8'hf0, 8'd0));
        row(OP_HOST_WRITE,   8'hff, 8'h00, 1'b1, res(1, 8'h00, 8'h00, 0, 8'h00, 8'hf0, 8'd0));
        row(OP_HOST_WRITE,   8'h5a, 8'h00, 1'b1, res(1, 8'h00, 8'h00, 0, 8'h00, 8'hf0, 8'd0));
        row(OP_TX_DONE,      8'h00, 8'h00, 1'b1, res(1, 8'h00, 8'h00, 1, 8'hff, 8'hf0, 8'd0));
        row(OP_TX_DONE,      8'h00, 8'h00, 1'b1, res(1, 8'h00, 8'h00, 1, 8'h5a, 8'hf0, 8'd0));
        row(OP_TX_DONE,      8'h00, 8'h00, 1'b1, res(0, 8'h00, 8'h00, 0, 8'h00, 8'hf0, 8'd0));
        row(OP_RX_BYTE,      8'h80, 8'h00, 1'b0, '0);
        row(OP_RX_ERROR,     8'h00, 8'h8f, 1'b0, '0);
        row(OP_HOST_READ,    8'h00, 8'h00, 1'b0, '0);
        row(OP_HOST_READ,    8'h00, 8'h00, 1'b0, '0);
        row(OP_HOST_READ,    8'h00, 8'h00, 1'b0, '0);
        row(OP_HOST_WRITE,   8'ha5, 8'h00, 1'b0, '0);
        row(OP_TX_DONE,      8'h00, 8'h00, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            present(dir_rows[i].op, dir_rows[i].data, dir_rows[i].line,
                    dir_rows[i].typed, dir_rows[i].want);

        // A threshold of zero sends XOFF on every receive that finds the transmitter idle and the ring not full.
        configure(8'hff, 1'b1, 9'd0);
        run_phase(150, 10, 4, 6, 6, 4, 1, 1);

        // Fill the receive ring past full while the output side holds off for a while.
        configure(8'h00, 1'b1, 9'd256);
        hold_req = 1'b1;
        run_phase(430, 50, 25, 6, 8, 6, 3, 2);

        configure(8'($urandom_range(1, 254)), 1'b0, XOFF_THRESHOLD_RESET);
        run_phase(250, 15, 5, 55, 10, 10, 3, 2);

        configure(8'h80, 1'b0, 9'h0ff);
        run_phase(450, 8, 2, 8, 70, 8, 2, 2);

        configure(8'($urandom_range(1, 254)), 1'b1, 9'($urandom_range(16, 160)));
        run_phase(300, 45, 10, 12, 6, 20, 4, 3);

        configure(RX_MASK_RESET, 1'b0, XOFF_THRESHOLD_RESET);
        calm = 1'b1;
        run_phase(250, 20, 8, 20, 20, 20, 6, 6);

        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d transactions and checked %0d results over six register settings.",
                 item_count, checked_count);
        $display("Saw %0d receive overruns, %0d XOFF sends, %0d dropped host writes, %0d long holds.",
                 overrun_count, xoff_count, tx_drop_count, holds_done);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
